[rtl/pcs_pkg.sv]
// Package for the Pauli S-conjugation block: payload structs, register
// indexes and phase constants. No dependencies.
`default_nettype none

package pcs_pkg;

  localparam int ROW_W       = 64;
  localparam int QUBITS_DEF  = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [1:0] PHASE_FWD  = 2'd1;
  localparam logic [1:0] PHASE_INV  = 2'd3;
  localparam logic [1:0] PHASE_SIGN = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_X,
    REG_AXIS_Z,
    REG_AXIS_NEG,
    REG_USE_INV
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_x_bits;
    logic [ROW_W-1:0] row_z_bits;
    logic             row_negative;
  } row_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_x_bits;
    logic [ROW_W-1:0] out_z_bits;
    logic             out_negative;
    logic             was_anticommuting;
  } result_t;

  typedef struct packed {
    logic anticommute;
    logic negative;
  } phase_t;

endpackage

`default_nettype wire

[rtl/pcs_phase.sv]
// Commutation test and sign of the conjugated row: parity of the symplectic
// product and a mod-4 adder tree over per-qubit phase terms. Uses pcs_pkg.
`default_nettype none

module pcs_phase
  import pcs_pkg::*;
(
  input  wire logic [ROW_W-1:0] px,
  input  wire logic [ROW_W-1:0] pz,
  input  wire logic [ROW_W-1:0] qx,
  input  wire logic [ROW_W-1:0] qz,
  input  wire logic             q_negative,
  input  wire logic             axis_negative,
  input  wire logic             use_inverse,
  output phase_t                phase
);

  localparam int NODES = 2 * ROW_W - 1;

  logic [ROW_W-1:0] plus;
  logic [ROW_W-1:0] minus;
  logic [1:0]       node [0:NODES-1];
  logic [1:0]       total;

  assign plus  = (px & ~pz & qx & qz) | (px & pz & ~qx & qz) | (~px & pz & qx & ~qz);
  assign minus = (px & ~pz & ~qx & qz) | (px & pz & qx & ~qz) | (~px & pz & qx & qz);

  // leaves: 0, +1 or -1 (mod 4) per qubit; heap-ordered sum tree
  for (genvar i = 0; i < ROW_W; i++) begin : g_leaf
    assign node[ROW_W-1+i] = {minus[i], plus[i] | minus[i]};
  end
  for (genvar k = 0; k < ROW_W - 1; k++) begin : g_sum
    assign node[k] = node[2*k+1] + node[2*k+2];
  end

  always_comb begin
    total = node[0] + (use_inverse ? PHASE_INV : PHASE_FWD);
    if (axis_negative) total = total + PHASE_SIGN;
    if (q_negative)    total = total + PHASE_SIGN;
    phase.anticommute = ^((px & qz) ^ (pz & qx));
    phase.negative    = (total == PHASE_SIGN);
  end

endmodule

`default_nettype wire

[rtl/pauli_conjugate_by_s_core.sv]
// Top level of the Pauli S-conjugation block: config registers, input and
// result registers. Uses pcs_pkg and pcs_phase.
//
// Takes one row per clock while row_stall is low and returns one result
// word per row, in order, through the input and result registers. The
// input register feeds the phase logic and XOR, the result register holds
// the answer; row_stall rises only while both registers are full and the
// result is stalled. Axis registers must be written while no row is in flight.
`default_nettype none

module pauli_conjugate_by_s_core
  import pcs_pkg::*;
#(
  parameter int QUBITS = QUBITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ROW_W-1:0]     cfg_data,
  input  wire logic                 row_valid,
  output      logic                 row_stall,
  input  wire row_t                 row_word,
  output      logic                 res_valid,
  input  wire logic                 res_stall,
  output      result_t              res_word
);

  localparam logic [ROW_W-1:0] QMASK = {ROW_W{1'b1}} >> (ROW_W - QUBITS);

  logic [ROW_W-1:0] axis_x_mask;
  logic [ROW_W-1:0] axis_z_mask;
  logic             axis_negative;
  logic             use_inverse;

  logic    s1_valid;
  row_t    s1_row;
  logic    res_ready;
  logic    s1_move;
  logic    row_take;
  phase_t  phase;
  result_t res_next;

  assign res_ready = !res_valid || !res_stall;
  assign s1_move   = s1_valid && res_ready;
  assign row_stall = s1_valid && !res_ready;
  assign row_take  = row_valid && !row_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x_mask   <= '0;
      axis_z_mask   <= '0;
      axis_negative <= 1'b0;
      use_inverse   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AXIS_X:   axis_x_mask   <= cfg_data;
        REG_AXIS_Z:   axis_z_mask   <= cfg_data;
        REG_AXIS_NEG: axis_negative <= cfg_data[0];
        REG_USE_INV:  use_inverse   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (row_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (row_take) begin
      s1_row.row_x_bits   <= row_word.row_x_bits & QMASK;
      s1_row.row_z_bits   <= row_word.row_z_bits & QMASK;
      s1_row.row_negative <= row_word.row_negative;
    end
  end

  pcs_phase u_phase (
    .px            (axis_x_mask & QMASK),
    .pz            (axis_z_mask & QMASK),
    .qx            (s1_row.row_x_bits),
    .qz            (s1_row.row_z_bits),
    .q_negative    (s1_row.row_negative),
    .axis_negative (axis_negative),
    .use_inverse   (use_inverse),
    .phase         (phase)
  );

  always_comb begin
    if (phase.anticommute) begin
      res_next.out_x_bits   = s1_row.row_x_bits ^ (axis_x_mask & QMASK);
      res_next.out_z_bits   = s1_row.row_z_bits ^ (axis_z_mask & QMASK);
      res_next.out_negative = phase.negative;
    end else begin
      res_next.out_x_bits   = s1_row.row_x_bits;
      res_next.out_z_bits   = s1_row.row_z_bits;
      res_next.out_negative = s1_row.row_negative;
    end
    res_next.was_anticommuting = phase.anticommute;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= s1_valid;
    end
    if (s1_move) begin
      res_word <= res_next;
    end
  end

endmodule

`default_nettype wire

[rtl/pcs_checker.sv]
// Port-level checks for pauli_conjugate_by_s_core, bound to the top level.
// Uses pcs_pkg.
`default_nettype none

module pcs_checker
  import pcs_pkg::*;
#(
  parameter int QUBITS = QUBITS_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    row_stall,
  input wire logic    res_valid,
  input wire logic    res_stall,
  input wire result_t res_word
);

  localparam logic [ROW_W-1:0] QMASK = {ROW_W{1'b1}} >> (ROW_W - QUBITS);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("result word changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    row_stall |-> res_valid && res_stall)
    else $error("row stalled while result side can drain");

  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_word.out_x_bits | res_word.out_z_bits) & ~QMASK) == '0)
    else $error("result bits set above qubit count");

  a_anti_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.was_anticommuting |->
      (res_word.out_x_bits | res_word.out_z_bits) != '0)
    else $error("anticommuting row mapped to identity");

endmodule

bind pauli_conjugate_by_s_core pcs_checker #(.QUBITS(QUBITS)) u_pcs_checker (
  .clk       (clk),
  .rst       (rst),
  .row_stall (row_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_word  (res_word)
);

`default_nettype wire
